[src/char_lcd_4bit_bus_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD bus sequencer
// Shared property templates; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_BUS_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lcdb_pkg.sv]
// ----------------------------------------------------------------------------
// LCD bus sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package lcdb_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  HALF_US_TICKS_RST = 8'd25;
  localparam logic [15:0] POWER_ON_RST      = 16'd60000;

  localparam logic [7:0] CMD_DISPLAY_ON   = 8'b0000_1100;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'b0010_1000;
  localparam logic [7:0] CMD_CGRAM_ADDR   = 8'b0100_0000;
  localparam logic [7:0] CMD_DDRAM_ADDR   = 8'b1000_0000;
  localparam logic [3:0] NIB_INIT         = 4'b0010;
  localparam int unsigned BUSY_BIT        = 7;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SEND = 2'd1,
    FUNC_INIT = 2'd2,
    FUNC_RSVD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_SEND,
    KIND_INIT,
    KIND_NOP
  } kind_t;

  typedef enum logic {
    CFG_HALF_US_TICKS    = 1'b0,
    CFG_POWER_ON_HALF_US = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PWR, PH_ISET, PH_IE, PH_IL,
    PH_WSET, PH_WHE, PH_WHL, PH_WLE, PH_WLL,
    PH_BSET, PH_BH1, PH_BH2, PH_BL1, PH_BH3, PH_BH4, PH_BL2
  } phase_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_DISPLAY,
    STEP_FUNCSET,
    STEP_CGRAM,
    STEP_DDRAM
  } init_step_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic       is_data;
    logic [1:0] style;
    logic [3:0] pin_nibble;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef struct packed {
    logic       lcd_e;
    logic       lcd_rs;
    logic       lcd_rw;
    logic [3:0] data_nibble;
    logic       data_drive;
    logic       ready_res;
    logic [7:0] last_status;
  } result_t;

endpackage

[src/lcdb_if.sv]
// ----------------------------------------------------------------------------
// LCD bus sequencer channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lcdb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] byte_value;
  logic       is_data;
  logic [1:0] style;
  logic [3:0] pin_nibble;

  modport source (output valid, func, byte_value, is_data, style, pin_nibble,
                  input ready);
  modport sink (input valid, func, byte_value, is_data, style, pin_nibble,
                output ready);
endinterface

interface lcdb_out_if;
  logic       valid;
  logic       ready;
  logic       lcd_e;
  logic       lcd_rs;
  logic       lcd_rw;
  logic [3:0] data_nibble;
  logic       data_drive;
  logic       ready_res;
  logic [7:0] last_status;

  modport source (output valid, lcd_e, lcd_rs, lcd_rw, data_nibble, data_drive,
                  ready_res, last_status, input ready);
  modport sink (input valid, lcd_e, lcd_rs, lcd_rw, data_nibble, data_drive,
                ready_res, last_status, output ready);
endinterface

interface lcdb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/lcdb_front.sv]
// ----------------------------------------------------------------------------
// LCD bus sequencer front end
// Accepts request items and classifies them into queue entries.
// ----------------------------------------------------------------------------
module lcdb_front (
  lcdb_in_if.sink           in_if,
  input  lcdb_pkg::q_stat_t q_stat,
  output lcdb_pkg::q_push_t q_push
);
  import lcdb_pkg::*;

  kind_t kind;

  always_comb begin
    case (func_t'(in_if.func))
      FUNC_TICK: kind = KIND_TICK;
      FUNC_SEND: kind = KIND_SEND;
      FUNC_INIT: kind = KIND_INIT;
      default:   kind = KIND_NOP;
    endcase
  end

  assign in_if.ready             = !q_stat.full;
  assign q_push.push             = in_if.valid && !q_stat.full;
  assign q_push.entry.kind       = kind;
  assign q_push.entry.byte_value = in_if.byte_value;
  assign q_push.entry.is_data    = in_if.is_data;
  assign q_push.entry.style      = in_if.style;
  assign q_push.entry.pin_nibble = in_if.pin_nibble;

endmodule

[src/lcdb_queue.sv]
// ----------------------------------------------------------------------------
// LCD bus sequencer item queue
// Short first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module lcdb_queue #(
  parameter int unsigned DEPTH = lcdb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdb_pkg::q_push_t  q_push,
  input  logic               pop,
  output lcdb_pkg::q_stat_t  q_stat,
  output lcdb_pkg::q_entry_t head
);
  import lcdb_pkg::*;

  `include "char_lcd_4bit_bus_sequencer_macros.svh"

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !q_push.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign head         = entries_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.avail = (count_r != '0);

  `LCDB_ASSERT_SAME(a_no_push_when_full, q_push.push, count_r < FULL_CNT,
                    "Item pushed into a full queue.")
  `LCDB_ASSERT_SAME(a_no_pop_when_empty, pop, count_r != '0,
                    "Item popped from an empty queue.")
  `LCDB_ASSERT_NEXT(a_count_tracks, q_push.push && !pop, count_r == $past(count_r) + 1'b1,
                    "Queue count did not follow a lone push.")

endmodule

[src/lcdb_back.sv]
// ----------------------------------------------------------------------------
// LCD bus sequencer back end
// Runs the pin sequence and busy polling, and registers one result per item.
// ----------------------------------------------------------------------------
module lcdb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         half_us_ticks,
  input  logic [15:0]        power_on_half_us,
  input  lcdb_pkg::q_entry_t head,
  input  logic               head_valid,
  output logic               pop,
  lcdb_out_if.source         out_if
);
  import lcdb_pkg::*;

  `include "char_lcd_4bit_bus_sequencer_macros.svh"

  phase_t     phase_r, phase_nxt;
  logic [7:0] prescale_r, prescale_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_rs_r, pend_rs_nxt;
  logic [7:0] status_r, status_nxt;
  init_step_t step_r, step_nxt;
  logic [1:0] style_r, style_nxt;
  logic       e_r, e_nxt;
  logic       rs_r, rs_nxt;
  logic       rw_r, rw_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       drv_r, drv_nxt;
  logic       out_valid_r;
  result_t    out_data_r;
  result_t    res;

  logic       idle;
  logic       unit_done;
  logic [7:0] cmd;

  assign idle      = (phase_r == PH_IDLE);
  assign pop       = head_valid && (!out_valid_r || out_if.ready);
  assign unit_done = ({1'b0, prescale_r} + 9'd1) >= {1'b0, half_us_ticks};

  always_comb begin
    phase_nxt     = phase_r;
    prescale_nxt  = prescale_r;
    delay_nxt     = delay_r;
    pend_byte_nxt = pend_byte_r;
    pend_rs_nxt   = pend_rs_r;
    status_nxt    = status_r;
    step_nxt      = step_r;
    style_nxt     = style_r;
    e_nxt         = e_r;
    rs_nxt        = rs_r;
    rw_nxt        = rw_r;
    nib_nxt       = nib_r;
    drv_nxt       = drv_r;
    cmd           = CMD_DDRAM_ADDR;
    case (step_r)
      STEP_DISPLAY: cmd = CMD_DISPLAY_ON | {6'b0, style_r};
      STEP_FUNCSET: cmd = CMD_FUNCTION_SET;
      STEP_CGRAM:   cmd = CMD_CGRAM_ADDR;
      default:      cmd = CMD_DDRAM_ADDR;
    endcase
    if (pop) begin
      case (head.kind)
        KIND_TICK: begin
          if (!idle) begin
            if (unit_done) begin
              prescale_nxt = '0;
              if (delay_r > 16'd1) begin
                delay_nxt = delay_r - 16'd1;
              end else begin
                case (phase_r)
                  PH_PWR: begin
                    e_nxt = 1'b0; rs_nxt = 1'b0; rw_nxt = 1'b0;
                    nib_nxt = '0; drv_nxt = 1'b1;
                    phase_nxt = PH_ISET; delay_nxt = 16'd1;
                  end
                  PH_ISET: begin
                    e_nxt = 1'b1; nib_nxt = NIB_INIT;
                    phase_nxt = PH_IE; delay_nxt = 16'd2;
                  end
                  PH_IE: begin
                    e_nxt = 1'b0; phase_nxt = PH_IL; delay_nxt = 16'd2;
                  end
                  PH_IL, PH_WLL: begin
                    drv_nxt = 1'b0; rw_nxt = 1'b1; rs_nxt = 1'b0;
                    phase_nxt = PH_BSET; delay_nxt = 16'd1;
                  end
                  PH_WSET: begin
                    e_nxt = 1'b1; nib_nxt = pend_byte_r[7:4];
                    phase_nxt = PH_WHE; delay_nxt = 16'd2;
                  end
                  PH_WHE: begin
                    e_nxt = 1'b0; phase_nxt = PH_WHL; delay_nxt = 16'd2;
                  end
                  PH_WHL: begin
                    e_nxt = 1'b1; nib_nxt = pend_byte_r[3:0];
                    phase_nxt = PH_WLE; delay_nxt = 16'd2;
                  end
                  PH_WLE: begin
                    e_nxt = 1'b0; phase_nxt = PH_WLL; delay_nxt = 16'd2;
                  end
                  PH_BSET: begin
                    e_nxt = 1'b1; phase_nxt = PH_BH1; delay_nxt = 16'd1;
                  end
                  PH_BH1: begin
                    status_nxt = {head.pin_nibble, 4'b0000};
                    phase_nxt = PH_BH2; delay_nxt = 16'd1;
                  end
                  PH_BH2: begin
                    e_nxt = 1'b0; phase_nxt = PH_BL1; delay_nxt = 16'd2;
                  end
                  PH_BL1: begin
                    e_nxt = 1'b1; phase_nxt = PH_BH3; delay_nxt = 16'd1;
                  end
                  PH_BH3: begin
                    status_nxt = {status_r[7:4], head.pin_nibble};
                    phase_nxt = PH_BH4; delay_nxt = 16'd1;
                  end
                  PH_BH4: begin
                    e_nxt = 1'b0; phase_nxt = PH_BL2; delay_nxt = 16'd2;
                  end
                  PH_BL2: begin
                    if (status_r[BUSY_BIT]) begin
                      e_nxt = 1'b1; phase_nxt = PH_BH1; delay_nxt = 16'd1;
                    end else if (step_r == STEP_DISPLAY || step_r == STEP_FUNCSET ||
                                 step_r == STEP_CGRAM || step_r == STEP_DDRAM) begin
                      step_nxt = init_step_t'(step_r + 3'd1);
                      pend_byte_nxt = cmd; pend_rs_nxt = 1'b0;
                      e_nxt = 1'b0; rs_nxt = 1'b0; rw_nxt = 1'b0; drv_nxt = 1'b1;
                      phase_nxt = PH_WSET; delay_nxt = 16'd1;
                    end else begin
                      rw_nxt = 1'b0; drv_nxt = 1'b1;
                      step_nxt = STEP_NONE;
                      phase_nxt = PH_IDLE; delay_nxt = '0;
                    end
                  end
                  default: begin
                    phase_nxt = PH_IDLE; delay_nxt = '0;
                  end
                endcase
              end
            end else begin
              prescale_nxt = prescale_r + 8'd1;
            end
          end
        end
        KIND_SEND: begin
          if (idle) begin
            prescale_nxt  = '0;
            step_nxt      = STEP_NONE;
            pend_byte_nxt = head.byte_value;
            pend_rs_nxt   = head.is_data;
            e_nxt = 1'b0; rs_nxt = head.is_data; rw_nxt = 1'b0; drv_nxt = 1'b1;
            phase_nxt = PH_WSET; delay_nxt = 16'd1;
          end
        end
        KIND_INIT: begin
          if (idle) begin
            prescale_nxt = '0;
            style_nxt    = head.style;
            step_nxt     = STEP_DISPLAY;
            phase_nxt    = PH_PWR;
            delay_nxt    = power_on_half_us;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    res.lcd_e       = e_nxt;
    res.lcd_rs      = rs_nxt;
    res.lcd_rw      = rw_nxt;
    res.data_nibble = nib_nxt;
    res.data_drive  = drv_nxt;
    res.ready_res   = (phase_nxt == PH_IDLE);
    res.last_status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      prescale_r  <= '0;
      delay_r     <= '0;
      pend_byte_r <= '0;
      pend_rs_r   <= 1'b0;
      status_r    <= '0;
      step_r      <= STEP_NONE;
      style_r     <= '0;
      e_r         <= 1'b0;
      rs_r        <= 1'b0;
      rw_r        <= 1'b0;
      nib_r       <= '0;
      drv_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prescale_r  <= prescale_nxt;
      delay_r     <= delay_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_rs_r   <= pend_rs_nxt;
      status_r    <= status_nxt;
      step_r      <= step_nxt;
      style_r     <= style_nxt;
      e_r         <= e_nxt;
      rs_r        <= rs_nxt;
      rw_r        <= rw_nxt;
      nib_r       <= nib_nxt;
      drv_r       <= drv_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.lcd_e       = out_data_r.lcd_e;
  assign out_if.lcd_rs      = out_data_r.lcd_rs;
  assign out_if.lcd_rw      = out_data_r.lcd_rw;
  assign out_if.data_nibble = out_data_r.data_nibble;
  assign out_if.data_drive  = out_data_r.data_drive;
  assign out_if.ready_res   = out_data_r.ready_res;
  assign out_if.last_status = out_data_r.last_status;

  `LCDB_ASSERT_SAME(a_idle_bus_parked, idle, !e_r && !rw_r && drv_r,
                    "Bus not parked while the sequencer is idle.")
  `LCDB_ASSERT_SAME(a_release_only_for_read, !drv_r, rw_r && !rs_r,
                    "Data lines released outside a status read.")
  `LCDB_ASSERT_NEXT(a_idle_keeps_prescale, idle && !(pop && head.kind == KIND_INIT) &&
                    !(pop && head.kind == KIND_SEND), prescale_r == '0,
                    "Prescaler moved while the sequencer was idle.")

endmodule

[src/char_lcd_4bit_bus_sequencer.sv]
// ----------------------------------------------------------------------------
// Character LCD 4-bit bus sequencer
// Drives a character LCD controller over a 4-bit bus.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle sustained while results are taken
// and returns exactly one result item for each. An accepted item is classified
// by the front end and placed in a short queue (QUEUE_DEPTH entries, two by
// default); the back end pin sequencer likewise takes one queued item per
// cycle, applies it in a single step and registers the resulting line levels;
// an item is held in a queue entry and then in the output register. Stalls on
// the result side fill the queue and then hold off new items. Time on the LCD
// bus advances only with tick items, half_us_ticks of them per half
// microsecond unit. The configuration port is always ready and must only be
// written while the block has no outstanding items.
module char_lcd_4bit_bus_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lcdb_pkg::QUEUE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lcdb_in_if.sink     in_if,
  lcdb_out_if.source  out_if,
  lcdb_cfg_if.sink    cfg_if
);
  import lcdb_pkg::*;

  logic [7:0]  half_us_ticks_r;
  logic [15:0] power_on_r;
  q_stat_t     q_stat;
  q_push_t     q_push;
  q_entry_t    head;
  logic        pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_us_ticks_r <= HALF_US_TICKS_RST;
      power_on_r      <= POWER_ON_RST;
    end else if (cfg_if.valid) begin
      case (cfg_idx_t'(cfg_if.index))
        CFG_HALF_US_TICKS:    half_us_ticks_r <= cfg_if.data[7:0];
        CFG_POWER_ON_HALF_US: power_on_r      <= cfg_if.data;
        default:              power_on_r      <= power_on_r;
      endcase
    end
  end

  lcdb_front u_front (
    .in_if  (in_if),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  lcdb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  lcdb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .half_us_ticks    (half_us_ticks_r),
    .power_on_half_us (power_on_r),
    .head             (head),
    .head_valid       (q_stat.avail),
    .pop              (pop),
    .out_if           (out_if)
  );

endmodule
